// ===== rtl/pasel_pkg.sv =====
// ----------------------------------------------------------------------------
// pasel_pkg
// Shared types and constants of the program stream audio selector.
// ----------------------------------------------------------------------------
package pasel_pkg;

    typedef enum logic [1:0] {
        PH_SCAN = 2'd0,
        PH_HEAD = 2'd1,
        PH_SKIP = 2'd2,
        PH_DATA = 2'd3
    } phase_t;

    // Position inside the fixed packet header, counted from the first zero of
    // the start code.
    localparam logic [3:0] HDR_NONE   = 4'd0;
    localparam logic [3:0] HDR_ID     = 4'd3;
    localparam logic [3:0] HDR_LEN_HI = 4'd4;
    localparam logic [3:0] HDR_LEN_LO = 4'd5;
    localparam logic [3:0] HDR_FLAG1  = 4'd6;
    localparam logic [3:0] HDR_FLAG2  = 4'd7;
    localparam logic [3:0] HDR_HLEN   = 4'd8;

    localparam logic [7:0] ID_PRIVATE_1 = 8'hBD;
    localparam logic [7:0] ID_PADDING   = 8'hBE;
    localparam logic [7:0] ID_PRIVATE_2 = 8'hBF;
    localparam logic [7:0] ID_AUDIO_0   = 8'hC0;
    localparam logic [7:0] ID_AUDIO_1   = 8'hC1;

    localparam logic [7:0] FLAG_MASK    = 8'hC0;
    localparam logic [7:0] FLAG_MARKER  = 8'h80;

    localparam logic [7:0] EXTRA_AUDIO_RESET = 8'd194;

    localparam logic CFG_WANTED_ID = 1'b0;
    localparam logic CFG_EXTRA_ID  = 1'b1;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] sid;
        logic       first;
        logic       last;
    } result_t;

endpackage

// ===== rtl/pes_audio_stream_selector_top.sv =====
// ----------------------------------------------------------------------------
// pes_audio_stream_selector_top
// Parses an MPEG-2 program stream byte by byte and passes the payload bytes
// of one selected (by default the first audio) stream.
// ----------------------------------------------------------------------------
//
//   channel   signals                                   direction
//   -------   ----------------------------------------  ---------
//   input     in_valid, in_stall, in_byte               into block
//   output    out_valid, out_stall, out_byte,           out of block
//             packet_stream_id, first_of_packet,
//             last_of_packet
//   config    cfg_wr_en, cfg_index, cfg_data            into block
//
// Every input transfer is handled in the cycle it is taken, so one byte per
// cycle is sustained while in_stall is low; the parser state register
// closes the only loop. Each result is registered before it is output.
// A two-entry output stage (output register plus skid register) lets the
// input keep flowing while a result waits; in_stall rises only once the
// skid register holds a result, and it comes straight from that register.
// Reset is asynchronous and active low; it puts the parser back to the
// start code search and restores the register defaults.
// ----------------------------------------------------------------------------
module pes_audio_stream_selector_top (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [7:0] packet_stream_id,
    output logic       first_of_packet,
    output logic       last_of_packet
);

    // Configuration registers.
    logic [7:0] wanted_id_reg;
    logic [7:0] extra_id_reg;

    // Parser state.
    pasel_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  zero_run_reg, zero_run_next;
    logic [3:0]  hdr_idx_reg, hdr_idx_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  opt_left_reg, opt_left_next;
    logic [7:0]  cur_id_reg, cur_id_next;
    logic [7:0]  latched_id_reg, latched_id_next;
    logic        first_pend_reg, first_pend_next;

    // Output stage.
    logic                 out_valid_reg;
    pasel_pkg::result_t   out_reg;
    logic                 skid_valid_reg;
    pasel_pkg::result_t   skid_reg;

    logic                 in_take;
    logic                 res_valid;
    pasel_pkg::result_t   res;

    logic        audio_type;
    logic        selected;
    logic [15:0] len_full;
    logic [15:0] bl_dec;
    logic [7:0]  opt_dec;

    assign in_stall = skid_valid_reg;
    assign in_take  = in_valid && !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_id_reg <= 8'd0;
            extra_id_reg  <= pasel_pkg::EXTRA_AUDIO_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                pasel_pkg::CFG_WANTED_ID: wanted_id_reg <= cfg_data;
                pasel_pkg::CFG_EXTRA_ID:  extra_id_reg  <= cfg_data;
                default:                  wanted_id_reg <= wanted_id_reg;
            endcase
        end
    end

    assign audio_type = (cur_id_reg == pasel_pkg::ID_PRIVATE_1) ||
                        (cur_id_reg == pasel_pkg::ID_AUDIO_0) ||
                        (cur_id_reg == pasel_pkg::ID_AUDIO_1) ||
                        (cur_id_reg == extra_id_reg);

    assign selected = (wanted_id_reg != 8'd0) ? (cur_id_reg == wanted_id_reg)
                    : ((latched_id_reg != 8'd0) && (cur_id_reg == latched_id_reg));

    assign len_full = {bytes_left_reg[15:8], in_byte};
    assign bl_dec   = bytes_left_reg - 16'd1;
    assign opt_dec  = opt_left_reg - 8'd1;

    // Next parser state and the result of the byte being transferred.
    always_comb
    begin
        phase_next      = phase_reg;
        zero_run_next   = zero_run_reg;
        hdr_idx_next    = hdr_idx_reg;
        bytes_left_next = bytes_left_reg;
        opt_left_next   = opt_left_reg;
        cur_id_next     = cur_id_reg;
        latched_id_next = latched_id_reg;
        first_pend_next = first_pend_reg;
        res_valid       = 1'b0;
        res.data        = in_byte;
        res.sid         = cur_id_reg;
        res.first       = first_pend_reg;
        res.last        = 1'b0;

        if (in_take)
        begin
            unique case (phase_reg)
                pasel_pkg::PH_SCAN:
                begin
                    if (in_byte == 8'h01 && zero_run_reg == 2'd2)
                    begin
                        phase_next    = pasel_pkg::PH_HEAD;
                        hdr_idx_next  = pasel_pkg::HDR_ID;
                        zero_run_next = 2'd0;
                    end
                    else if (in_byte == 8'h00)
                        zero_run_next = (zero_run_reg == 2'd2) ? 2'd2 : zero_run_reg + 2'd1;
                    else
                        zero_run_next = 2'd0;
                end

                pasel_pkg::PH_HEAD:
                begin
                    if (hdr_idx_reg == pasel_pkg::HDR_ID)
                    begin
                        cur_id_next  = in_byte;
                        hdr_idx_next = pasel_pkg::HDR_LEN_HI;
                    end
                    else if (hdr_idx_reg == pasel_pkg::HDR_LEN_HI)
                    begin
                        bytes_left_next = {in_byte, 8'd0};
                        hdr_idx_next    = pasel_pkg::HDR_LEN_LO;
                    end
                    else if (hdr_idx_reg == pasel_pkg::HDR_LEN_LO)
                    begin
                        bytes_left_next = len_full;
                        if (cur_id_reg == pasel_pkg::ID_PADDING ||
                            cur_id_reg == pasel_pkg::ID_PRIVATE_2)
                        begin
                            if (len_full == 16'd0)
                            begin
                                phase_next      = pasel_pkg::PH_SCAN;
                                zero_run_next   = 2'd2;
                                hdr_idx_next    = pasel_pkg::HDR_NONE;
                                opt_left_next   = 8'd0;
                                first_pend_next = 1'b0;
                            end
                            else
                            begin
                                if (wanted_id_reg == 8'd0 && latched_id_reg == 8'd0 &&
                                    audio_type)
                                    latched_id_next = cur_id_reg;
                                phase_next      = pasel_pkg::PH_DATA;
                                first_pend_next = 1'b1;
                            end
                        end
                        else if (len_full < 16'd3)
                        begin
                            // A zero low length byte counts toward the next
                            // start code, two zeros if the high byte was zero.
                            phase_next      = pasel_pkg::PH_SCAN;
                            zero_run_next   = (in_byte != 8'd0) ? 2'd0
                                            : (bytes_left_reg == 16'd0) ? 2'd2 : 2'd1;
                            hdr_idx_next    = pasel_pkg::HDR_NONE;
                            opt_left_next   = 8'd0;
                            first_pend_next = 1'b0;
                        end
                        else
                            hdr_idx_next = pasel_pkg::HDR_FLAG1;
                    end
                    else if (hdr_idx_reg == pasel_pkg::HDR_FLAG1)
                    begin
                        if ((in_byte & pasel_pkg::FLAG_MASK) != pasel_pkg::FLAG_MARKER)
                        begin
                            phase_next      = pasel_pkg::PH_SCAN;
                            zero_run_next   = (in_byte == 8'd0) ? 2'd1 : 2'd0;
                            hdr_idx_next    = pasel_pkg::HDR_NONE;
                            opt_left_next   = 8'd0;
                            first_pend_next = 1'b0;
                        end
                        else
                        begin
                            bytes_left_next = bl_dec;
                            if (wanted_id_reg == 8'd0 && latched_id_reg == 8'd0 && audio_type)
                                latched_id_next = cur_id_reg;
                            hdr_idx_next = pasel_pkg::HDR_FLAG2;
                        end
                    end
                    else if (hdr_idx_reg == pasel_pkg::HDR_FLAG2)
                    begin
                        bytes_left_next = bl_dec;
                        hdr_idx_next    = pasel_pkg::HDR_HLEN;
                    end
                    else
                    begin
                        bytes_left_next = bl_dec;
                        opt_left_next   = in_byte;
                        if (bl_dec == 16'd0)
                        begin
                            phase_next      = pasel_pkg::PH_SCAN;
                            zero_run_next   = 2'd0;
                            hdr_idx_next    = pasel_pkg::HDR_NONE;
                            opt_left_next   = 8'd0;
                            first_pend_next = 1'b0;
                        end
                        else
                        begin
                            first_pend_next = 1'b1;
                            phase_next      = (in_byte == 8'd0) ? pasel_pkg::PH_DATA
                                                                : pasel_pkg::PH_SKIP;
                        end
                    end
                end

                pasel_pkg::PH_SKIP:
                begin
                    bytes_left_next = bl_dec;
                    opt_left_next   = opt_dec;
                    if (bl_dec == 16'd0)
                    begin
                        phase_next      = pasel_pkg::PH_SCAN;
                        zero_run_next   = 2'd0;
                        hdr_idx_next    = pasel_pkg::HDR_NONE;
                        opt_left_next   = 8'd0;
                        first_pend_next = 1'b0;
                    end
                    else if (opt_dec == 8'd0)
                        phase_next = pasel_pkg::PH_DATA;
                end

                pasel_pkg::PH_DATA:
                begin
                    bytes_left_next = bl_dec;
                    res_valid       = selected;
                    res.last        = (bl_dec == 16'd0);
                    if (selected)
                        first_pend_next = 1'b0;
                    if (bl_dec == 16'd0)
                    begin
                        phase_next      = pasel_pkg::PH_SCAN;
                        zero_run_next   = 2'd0;
                        hdr_idx_next    = pasel_pkg::HDR_NONE;
                        opt_left_next   = 8'd0;
                        first_pend_next = 1'b0;
                    end
                end

                default:
                begin
                    phase_next = pasel_pkg::PH_SCAN;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= pasel_pkg::PH_SCAN;
            zero_run_reg   <= 2'd0;
            hdr_idx_reg    <= pasel_pkg::HDR_NONE;
            bytes_left_reg <= 16'd0;
            opt_left_reg   <= 8'd0;
            cur_id_reg     <= 8'd0;
            latched_id_reg <= 8'd0;
            first_pend_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            zero_run_reg   <= zero_run_next;
            hdr_idx_reg    <= hdr_idx_next;
            bytes_left_reg <= bytes_left_next;
            opt_left_reg   <= opt_left_next;
            cur_id_reg     <= cur_id_next;
            latched_id_reg <= latched_id_next;
            first_pend_reg <= first_pend_next;
        end
    end

    // Output register with a skid register behind it. While the skid register
    // is full the input is stalled, so no new result can arrive then.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg  <= skid_valid_reg || res_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (res_valid)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
            out_reg <= skid_valid_reg ? skid_reg : res;
        else if (res_valid)
            skid_reg <= res;
    end

    assign out_valid        = out_valid_reg;
    assign out_byte         = out_reg.data;
    assign packet_stream_id = out_reg.sid;
    assign first_of_packet  = out_reg.first;
    assign last_of_packet   = out_reg.last;

endmodule
